// ===== rtl/gs3_pkg.sv =====
package gs3_pkg;

	// width of the sweep count fields
	localparam int SWEEP_W = 7;

	// matrix store geometry
	localparam int NUM_ROWS = 3;
	localparam int NUM_COLS = 4;

	// column codes, also the code of the variable solved from that row
	localparam logic [1:0] COL_X   = 2'd0;
	localparam logic [1:0] COL_Y   = 2'd1;
	localparam logic [1:0] COL_Z   = 2'd2;
	localparam logic [1:0] COL_RHS = 2'd3;

	// last legal row of a load beat
	localparam logic [1:0] ROW_LAST = 2'd2;

	// item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NUM,
		ST_MUL_START,
		ST_MUL,
		ST_ACC,
		ST_DIV_START,
		ST_DIV,
		ST_DIV_END,
		ST_EMIT
	} gs3_state_t;

	typedef struct packed {
		logic               wr_row;
		logic               set_init;
		logic               num_init;
		logic               err_clr;
		logic               mul_start;
		logic               mul_step;
		logic               acc_add;
		logic               div_start;
		logic               div_step;
		logic               div_end;
		logic               emit;
		logic [1:0]         var_sel;
		logic [1:0]         col_sel;
		logic [SWEEP_W-1:0] sweep;
		logic               last;
	} gs3_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} gs3_stat_t;

	// j-th off-diagonal column of the row that solves variable v
	function automatic logic [1:0] other_col(input logic [1:0] v, input logic j);
		logic [1:0] c;
		case (v)
			COL_X:   c = j ? COL_Z : COL_Y;
			COL_Y:   c = j ? COL_Z : COL_X;
			COL_Z:   c = j ? COL_Y : COL_X;
			default: c = COL_X;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/gs3_in_if.sv =====
interface gs3_in_if import gs3_pkg::*; #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [1:0]                   row;
	logic signed [DATA_WIDTH-1:0] coef_x;
	logic signed [DATA_WIDTH-1:0] coef_y;
	logic signed [DATA_WIDTH-1:0] coef_z;
	logic signed [DATA_WIDTH-1:0] rhs;
	logic signed [DATA_WIDTH-1:0] init_y;
	logic signed [DATA_WIDTH-1:0] init_z;
	logic [SWEEP_W-1:0]           iterations;

	modport source (
		output valid, kind, row, coef_x, coef_y, coef_z, rhs, init_y, init_z, iterations,
		input  ready
	);

	modport sink (
		input  valid, kind, row, coef_x, coef_y, coef_z, rhs, init_y, init_z, iterations,
		output ready
	);
endinterface

// ===== rtl/gs3_out_if.sv =====
interface gs3_out_if import gs3_pkg::*; #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic [SWEEP_W-1:0]           sweep;
	logic signed [DATA_WIDTH-1:0] x_value;
	logic signed [DATA_WIDTH-1:0] y_value;
	logic signed [DATA_WIDTH-1:0] z_value;
	logic                         div_error;
	logic                         last;

	modport source (
		output valid, sweep, x_value, y_value, z_value, div_error, last,
		input  ready
	);

	modport sink (
		input  valid, sweep, x_value, y_value, z_value, div_error, last,
		output ready
	);
endinterface

// ===== rtl/gs3_dpath.sv =====
module gs3_dpath import gs3_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gs3_cmd_t              cmd,
	output gs3_stat_t             stat,
	input  logic [1:0]            row,
	input  logic [DATA_WIDTH-1:0] coef_x,
	input  logic [DATA_WIDTH-1:0] coef_y,
	input  logic [DATA_WIDTH-1:0] coef_z,
	input  logic [DATA_WIDTH-1:0] rhs,
	input  logic [DATA_WIDTH-1:0] init_y,
	input  logic [DATA_WIDTH-1:0] init_z,
	output logic [SWEEP_W-1:0]    sweep,
	output logic [DATA_WIDTH-1:0] x_value,
	output logic [DATA_WIDTH-1:0] y_value,
	output logic [DATA_WIDTH-1:0] z_value,
	output logic                  div_error,
	output logic                  last
);
	localparam int DW  = DATA_WIDTH;
	localparam int PW  = 2 * DW;
	localparam int SW  = DW + FRAC_BITS;
	// signed numerator width, two bits of headroom over the widest term
	localparam int NW  = ((PW > SW) ? PW : SW) + 2;
	localparam int MW  = NW - 1;
	localparam int MCW = $clog2(DW);
	localparam int DCW = $clog2(MW);
	localparam logic [MCW-1:0] MUL_LAST = MCW'(DW - 1);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(MW - 1);

	logic [DW-1:0]  store_q [NUM_ROWS][NUM_COLS];
	logic [DW-1:0]  cur_q [NUM_ROWS];

	logic [DW-1:0]  rd_word;
	logic [DW-1:0]  rd_mag;
	logic [DW-1:0]  cur_word;
	logic [DW-1:0]  cur_mag;

	// shift-add multiplier
	logic [DW-1:0]  mcand_q;
	logic [PW:0]    prod_q;
	logic           psign_q;
	logic [MCW-1:0] mul_cnt_q;
	logic [DW:0]    mul_sum;
	logic [NW-1:0]  prod_ext;

	// numerator accumulator
	logic [NW-1:0]  acc_q;
	logic [NW-1:0]  acc_mag;

	// restoring divider
	logic [DW-1:0]  dmag_q;
	logic [MW-1:0]  num_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  quo_q;
	logic           ovf_q;
	logic           rneg_q;
	logic [DCW-1:0] div_cnt_q;
	logic [DW:0]    rem_sh;
	logic [DW:0]    rem_diff;
	logic           div_ge;
	logic [DW-1:0]  lim;
	logic           sat;
	logic [DW-1:0]  div_res;

	logic           err_q;

	assign rd_word  = store_q[cmd.var_sel][cmd.col_sel];
	assign rd_mag   = rd_word[DW-1] ? (~rd_word + 1'b1) : rd_word;
	assign cur_word = cur_q[cmd.col_sel];
	assign cur_mag  = cur_word[DW-1] ? (~cur_word + 1'b1) : cur_word;

	assign mul_sum  = prod_q[PW:DW] + (prod_q[0] ? {1'b0, mcand_q} : '0);
	assign prod_ext = NW'(prod_q);

	assign acc_mag  = acc_q[NW-1] ? (~acc_q + 1'b1) : acc_q;

	assign rem_sh   = {rem_q, num_q[MW-1]};
	assign rem_diff = rem_sh - {1'b0, dmag_q};
	assign div_ge   = rem_sh >= {1'b0, dmag_q};

	// zero divisor runs as all-ones quotient, caught by the overflow path
	assign lim      = rneg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
	assign sat      = ovf_q | (quo_q > lim);
	assign div_res  = sat ? lim : (rneg_q ? (~quo_q + 1'b1) : quo_q);

	assign stat.mul_done = (mul_cnt_q == MUL_LAST);
	assign stat.div_done = (div_cnt_q == DIV_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				for (int c = 0; c < NUM_COLS; c++) begin
					store_q[r][c] <= '0;
				end
				cur_q[r] <= '0;
			end
			mul_cnt_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.wr_row) begin
				store_q[row][COL_X]   <= coef_x;
				store_q[row][COL_Y]   <= coef_y;
				store_q[row][COL_Z]   <= coef_z;
				store_q[row][COL_RHS] <= rhs;
			end
			if (cmd.set_init) begin
				cur_q[COL_Y] <= init_y;
				cur_q[COL_Z] <= init_z;
			end
			if (cmd.div_end) begin
				cur_q[cmd.var_sel] <= div_res;
			end
			if (cmd.mul_start) begin
				mul_cnt_q <= '0;
			end else if (cmd.mul_step) begin
				mul_cnt_q <= mul_cnt_q + 1'b1;
			end
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.num_init) begin
			acc_q <= {{(NW-DW){rd_word[DW-1]}}, rd_word} << FRAC_BITS;
		end else if (cmd.acc_add) begin
			acc_q <= psign_q ? (acc_q + prod_ext) : (acc_q - prod_ext);
		end

		if (cmd.mul_start) begin
			mcand_q <= rd_mag;
			prod_q  <= {{(DW+1){1'b0}}, cur_mag};
			psign_q <= rd_word[DW-1] ^ cur_word[DW-1];
		end else if (cmd.mul_step) begin
			prod_q  <= {1'b0, mul_sum, prod_q[DW-1:1]};
		end

		if (cmd.div_start) begin
			num_q  <= acc_mag[MW-1:0];
			dmag_q <= rd_mag;
			rneg_q <= acc_q[NW-1] ^ rd_word[DW-1];
			rem_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.div_step) begin
			num_q  <= {num_q[MW-2:0], 1'b0};
			rem_q  <= div_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q  <= {quo_q[DW-2:0], div_ge};
			ovf_q  <= ovf_q | quo_q[DW-1];
		end

		if (cmd.err_clr) begin
			err_q <= 1'b0;
		end else if (cmd.div_end) begin
			err_q <= err_q | sat;
		end

		if (cmd.emit) begin
			sweep     <= cmd.sweep;
			x_value   <= cur_q[COL_X];
			y_value   <= cur_q[COL_Y];
			z_value   <= cur_q[COL_Z];
			div_error <= err_q;
			last      <= cmd.last;
		end
	end
endmodule

// ===== rtl/gs3_ctrl.sv =====
module gs3_ctrl import gs3_pkg::*; #(
	parameter int MAX_SWEEPS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [1:0]         row,
	input  logic [SWEEP_W-1:0] iterations,
	output logic               out_valid,
	input  logic               out_ready,
	input  gs3_stat_t          stat,
	output gs3_cmd_t           cmd
);
	localparam logic [SWEEP_W-1:0] SWEEP_MAX = SWEEP_W'(MAX_SWEEPS);

	gs3_state_t         state_q, state_d;
	logic [SWEEP_W-1:0] n_q, n_d;
	logic [SWEEP_W-1:0] sweep_q, sweep_d;
	logic [1:0]         var_q, var_d;
	logic               prod_q, prod_d;
	logic               out_valid_q, out_valid_d;
	logic [SWEEP_W-1:0] iter_clamped;
	logic               out_free;

	assign iter_clamped = (iterations > SWEEP_MAX) ? SWEEP_MAX : iterations;
	assign out_free     = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			sweep_q     <= '0;
			var_q       <= COL_X;
			prod_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			n_q         <= n_d;
			sweep_q     <= sweep_d;
			var_q       <= var_d;
			prod_q      <= prod_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		sweep_d     = sweep_q;
		var_d       = var_q;
		prod_d      = prod_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = (state_q == ST_IDLE);
		cmd         = '0;
		cmd.var_sel = var_q;
		cmd.col_sel = var_q;
		cmd.sweep   = sweep_q;
		cmd.last    = (sweep_q == n_q);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (kind == KIND_LOAD) begin
						cmd.wr_row = (row <= ROW_LAST);
					end else begin
						cmd.set_init = 1'b1;
						n_d          = iter_clamped;
						sweep_d      = SWEEP_W'(1);
						var_d        = COL_X;
						if (iter_clamped != '0) begin
							state_d = ST_NUM;
						end
					end
				end
			end
			ST_NUM: begin
				cmd.col_sel  = COL_RHS;
				cmd.num_init = 1'b1;
				cmd.err_clr  = (var_q == COL_X);
				prod_d       = 1'b0;
				state_d      = ST_MUL_START;
			end
			ST_MUL_START: begin
				cmd.col_sel   = other_col(var_q, prod_q);
				cmd.mul_start = 1'b1;
				state_d       = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				if (prod_q) begin
					state_d = ST_DIV_START;
				end else begin
					prod_d  = 1'b1;
					state_d = ST_MUL_START;
				end
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				cmd.div_end = 1'b1;
				if (var_q == COL_Z) begin
					state_d = ST_EMIT;
				end else begin
					var_d   = var_q + 1'b1;
					state_d = ST_NUM;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit    = 1'b1;
					out_valid_d = 1'b1;
					var_d       = COL_X;
					if (sweep_q == n_q) begin
						state_d = ST_IDLE;
					end else begin
						sweep_d = sweep_q + 1'b1;
						state_d = ST_NUM;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result written over a beat not yet taken");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_IDLE))
		else $error("run did not end after its last sweep");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (sweep_q != '0 && sweep_q <= n_q && n_q <= SWEEP_MAX))
		else $error("sweep count out of range");

	a_var_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (var_q != COL_RHS))
		else $error("variable index beyond z");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("output valid raised without a result");
`endif
endmodule

// ===== rtl/gauss_seidel_3x3_solver_core.sv =====
// gauss-seidel solver for a 3x3 system, signed fixed point (Q16.16 by default)
// req channel: a load beat (kind 0) writes row 0..2 of coefficients and rhs,
//   rows beyond two are dropped; a run beat (kind 1) sets y and z to init_y and
//   init_z and runs min(iterations, MAX_SWEEPS) sweeps, zero sweeps give no beat
// rsp channel: one beat per sweep with sweep number, x, y, z, div_error and
//   last on the final sweep of the run
// sweep timing is set by the bit-serial multiplier (one bit per cycle, six
//   products) and the restoring divider (one quotient bit per cycle, three
//   divisions); a load beat is written in the cycle it is accepted
// throughput: one run at a time, req.ready is high only between runs
// a stalled rsp holds the sweep result in the output register; the next sweep
//   is computed meanwhile and waits until the held beat is taken
// reset clears the matrix store and x, y, z to zero and leaves the block idle
module gauss_seidel_3x3_solver_core import gs3_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int MAX_SWEEPS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	gs3_in_if.sink    req,
	gs3_out_if.source rsp
);
	// command and status between sequencer and datapath
	gs3_cmd_t  cmd;
	gs3_stat_t stat;

	// sequencer: handshakes, sweep and variable counting, output valid
	gs3_ctrl #(
		.MAX_SWEEPS (MAX_SWEEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.kind       (req.kind),
		.row        (req.row),
		.iterations (req.iterations),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: matrix store, current solution, multiplier, divider, rsp payload
	gs3_dpath #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.row       (req.row),
		.coef_x    (req.coef_x),
		.coef_y    (req.coef_y),
		.coef_z    (req.coef_z),
		.rhs       (req.rhs),
		.init_y    (req.init_y),
		.init_z    (req.init_z),
		.sweep     (rsp.sweep),
		.x_value   (rsp.x_value),
		.y_value   (rsp.y_value),
		.z_value   (rsp.z_value),
		.div_error (rsp.div_error),
		.last      (rsp.last)
	);
endmodule
